/* design/csct_pkg.sv */
package csct_pkg;

    // Widths of the payload fields.
    localparam int ID_FIELD_W = 16;
    localparam int CHANGE_W   = 2;

    // Item kinds.
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Change codes carried by a result.
    localparam logic [CHANGE_W-1:0] CHG_STARTED   = 2'd0;
    localparam logic [CHANGE_W-1:0] CHG_PERSISTED = 2'd1;
    localparam logic [CHANGE_W-1:0] CHG_ENDED     = 2'd2;

    // One input item.
    typedef struct packed {
        logic                  kind;
        logic [ID_FIELD_W-1:0] object_id;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [CHANGE_W-1:0]   change;
        logic [ID_FIELD_W-1:0] other_id;
        logic                  last;
    } t_out_item;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                  add_en;
        logic [ID_FIELD_W-1:0] add_id;
        logic                  step_cur;
        logic                  shift_prev;
        logic                  swap;
        logic [ID_FIELD_W-1:0] head_id;
    } t_cell_cmd;

    // Contents one cell hands to its left neighbor.
    typedef struct packed {
        logic                  cur_valid;
        logic [ID_FIELD_W-1:0] cur_id;
        logic                  prev_valid;
        logic [ID_FIELD_W-1:0] prev_id;
        logic                  prev_matched;
    } t_cell_link;

    // Per-cell status gathered by the sequencer.
    typedef struct packed {
        logic dup_hit;
        logic match_hit;
        logic pend;
    } t_cell_stat;

endpackage

/* design/csct_cell.sv */
module csct_cell #(
    parameter int ID_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csct_pkg::t_cell_cmd  i_cmd,
    input  logic                i_left_valid,
    input  csct_pkg::t_cell_link i_right,
    output csct_pkg::t_cell_link o_link,
    output csct_pkg::t_cell_stat o_stat
);
    import csct_pkg::*;

    logic [ID_W-1:0] r_cur_id;
    logic            r_cur_valid;
    logic [ID_W-1:0] r_prev_id;
    logic            r_prev_valid;
    logic            r_matched;

    logic [ID_W-1:0] n_cur_id;
    logic            n_cur_valid;
    logic [ID_W-1:0] n_prev_id;
    logic            n_prev_valid;
    logic            n_matched;

    logic            w_pend;
    logic            w_match;
    logic            w_insert;

    // Compares against the broadcast identifiers.
    assign w_pend   = r_prev_valid && !r_matched;
    assign w_match  = w_pend && (r_prev_id == i_cmd.head_id[ID_W-1:0]);
    assign w_insert = i_cmd.add_en && !r_cur_valid && i_left_valid;

    assign o_stat.dup_hit   = r_cur_valid && (r_cur_id == i_cmd.add_id[ID_W-1:0]);
    assign o_stat.match_hit = w_match;
    assign o_stat.pend      = w_pend;

    assign o_link.cur_valid    = r_cur_valid;
    assign o_link.cur_id       = ID_FIELD_W'(r_cur_id);
    assign o_link.prev_valid   = r_prev_valid;
    assign o_link.prev_id      = ID_FIELD_W'(r_prev_id);
    assign o_link.prev_matched = r_matched;

    // Next contents: insert, rotate the current set, shift out the previous set, or swap.
    always_comb begin
        n_cur_id     = r_cur_id;
        n_cur_valid  = r_cur_valid;
        n_prev_id    = r_prev_id;
        n_prev_valid = r_prev_valid;
        n_matched    = r_matched;
        if (i_cmd.swap) begin
            n_prev_id    = r_cur_id;
            n_prev_valid = r_cur_valid;
            n_matched    = 1'b0;
            n_cur_valid  = 1'b0;
        end else begin
            if (w_insert) begin
                n_cur_id    = i_cmd.add_id[ID_W-1:0];
                n_cur_valid = 1'b1;
            end
            // The head entry wraps around into the last occupied cell.
            if (i_cmd.step_cur) begin
                if (r_cur_valid) begin
                    n_cur_id = i_right.cur_valid ? i_right.cur_id[ID_W-1:0]
                                                 : i_cmd.head_id[ID_W-1:0];
                end
                if (w_match) begin
                    n_matched = 1'b1;
                end
            end
            if (i_cmd.shift_prev) begin
                n_prev_id    = i_right.prev_id[ID_W-1:0];
                n_prev_valid = i_right.prev_valid;
                n_matched    = i_right.prev_matched;
            end
        end
    end

    // Valid and matched flags reset; identifiers do not.
    always_ff @(posedge i_clk) begin
        r_cur_id  <= n_cur_id;
        r_prev_id <= n_prev_id;
        if (!i_rst_n) begin
            r_cur_valid  <= 1'b0;
            r_prev_valid <= 1'b0;
            r_matched    <= 1'b0;
        end else begin
            r_cur_valid  <= n_cur_valid;
            r_prev_valid <= n_prev_valid;
            r_matched    <= n_matched;
        end
    end

endmodule

/* design/contact_set_change_tracker_core.sv */
// An add leaves the sequencer idle: the input stays ready for the next item.
// A tick rotates the C current entries through the head cell, one per cycle while
// the output is free, then shifts out the previous entries, one per cycle unless an
// unmatched head waits for the output, then swaps the sets. Each result is registered.
// Synchronous active-low reset empties both sets and clears the output valid flag.
module contact_set_change_tracker_core #(
    parameter int MAX_CONTACTS = 16,
    parameter int ID_BITS      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csct_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csct_pkg::t_out_item o_out_data
);
    import csct_pkg::*;

    localparam int MC      = MAX_CONTACTS;
    localparam int CNT_W   = $clog2(MAX_CONTACTS + 1);
    localparam int STORE_W = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CUR,
        S_END,
        S_SWAP
    } t_state;

    t_state     r_state, n_state;
    logic [CNT_W-1:0] r_cur_count, n_cur_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_data, n_out_data;

    t_cell_cmd  w_cmd;
    t_cell_link w_link  [MC];
    t_cell_link w_right [MC];
    t_cell_stat w_stat  [MC];
    logic [MC-1:0] w_cur_valid;
    logic [MC-1:0] w_dup;
    logic [MC-1:0] w_hit;
    logic [MC-1:0] w_pend;
    logic       w_in_fire;
    logic       w_out_free;
    logic       w_found;
    logic       w_pend_after;
    logic       w_rest_pend;

    // Row of cells; each takes its right neighbor's contents when shifting.
    for (genvar k = 0; k < MC; k++) begin : g_cell
        if (k == MC - 1) begin : g_tail
            assign w_right[k] = '0;
        end else begin : g_mid
            assign w_right[k] = w_link[k+1];
        end

        csct_cell #(
            .ID_W (STORE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left_valid ((k == 0) ? 1'b1 : w_cur_valid[(k == 0) ? 0 : k-1]),
            .i_right      (w_right[k]),
            .o_link       (w_link[k]),
            .o_stat       (w_stat[k])
        );

        assign w_cur_valid[k] = w_link[k].cur_valid;
        assign w_dup[k]       = w_stat[k].dup_hit;
        assign w_hit[k]       = w_stat[k].match_hit;
        assign w_pend[k]      = w_stat[k].pend;
    end

    // Handshake and summary flags.
    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_found      = |w_hit;
    assign w_pend_after = |(w_pend & ~w_hit);
    assign w_rest_pend  = |(w_pend >> 1);

    // Command broadcast to the row.
    always_comb begin
        w_cmd.add_en     = w_in_fire && (i_in_data.kind == KIND_ADD) && !(|w_dup)
                           && !w_cur_valid[MC-1];
        w_cmd.add_id     = i_in_data.object_id;
        w_cmd.step_cur   = (r_state == S_CUR) && w_out_free;
        w_cmd.shift_prev = (r_state == S_END) && (w_out_free || !w_pend[0]);
        w_cmd.swap       = (r_state == S_SWAP);
        w_cmd.head_id    = w_link[0].cur_id;
    end

    // Sequencer next state and result register.
    always_comb begin
        n_state     = r_state;
        n_cur_count = r_cur_count;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_cmd.add_en) begin
                    n_cur_count = r_cur_count + CNT_W'(1);
                end
                if (w_in_fire && (i_in_data.kind == KIND_TICK)) begin
                    n_left = r_cur_count;
                    if (r_cur_count != '0) begin
                        n_state = S_CUR;
                    end else if (|w_pend) begin
                        n_state = S_END;
                    end else begin
                        n_state = S_SWAP;
                    end
                end
            end
            S_CUR: begin
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_data.change   = w_found ? CHG_PERSISTED : CHG_STARTED;
                    n_out_data.other_id = w_link[0].cur_id;
                    n_out_data.last     = (r_left == CNT_W'(1)) && !w_pend_after;
                    n_left              = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = w_pend_after ? S_END : S_SWAP;
                    end
                end
            end
            S_END: begin
                // Matched entries at the head are dropped without a result.
                if (w_pend[0] && w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_data.change   = CHG_ENDED;
                    n_out_data.other_id = w_link[0].prev_id;
                    n_out_data.last     = !w_rest_pend;
                    if (!w_rest_pend) begin
                        n_state = S_SWAP;
                    end
                end
            end
            S_SWAP: begin
                n_cur_count = '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_left     <= n_left;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_count <= n_cur_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The current set always fills the row from the head without gaps.
    a_cur_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_cur_valid + MC'(1)) & w_cur_valid) == '0)
        else $error("current set has a gap");

    // The entry count tracks the occupied cells.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_cur_valid) == int'(r_cur_count))
        else $error("current count out of step with cells");

    // A final result is only produced on the way to the swap.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.last && !$stable(r_out_data))
            |-> (r_state == S_SWAP))
        else $error("last result produced outside the end of a tick");

    // After a swap the current set is empty.
    a_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP) |=> (w_cur_valid == '0))
        else $error("current set not emptied by swap");

endmodule
